>>> src/irt_pkg.sv
// Package with the sizes and the control structs shared by the interval range table files.
package irt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int KEY_BITS = 16;
	localparam int VALUE_BITS = 32;
	localparam int IDX_BITS = $clog2(TABLE_DEPTH);
	localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);

	localparam logic OP_ASSIGN = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic load;
		logic scan_chk;
		logic decide;
		logic sel_move;
		logic move_init;
		logic move_wr;
		logic put_b;
		logic put_e;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic finish_now;
		logic need_move;
		logic move_last;
		logic out_busy;
	} sts_t;

endpackage

>>> src/irt_ram.sv
// Generic single write port RAM with one registered read port.
module irt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/irt_ctrl.sv
// Controller state machine that sequences scan, shift and write steps of the table.
module irt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  irt_pkg::sts_t sts,
	output irt_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_DECIDE,
		S_MOVE_RD,
		S_MOVE_WR,
		S_PUT_B,
		S_PUT_E,
		S_RESULT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_SCAN_CHK: cmd.scan_chk = 1'b1;
			S_DECIDE: begin
				cmd.decide = 1'b1;
				cmd.move_init = !sts.finish_now && sts.need_move;
			end
			S_MOVE_RD: cmd.sel_move = 1'b1;
			S_MOVE_WR: begin
				cmd.sel_move = 1'b1;
				cmd.move_wr = 1'b1;
			end
			S_PUT_B: cmd.put_b = 1'b1;
			S_PUT_E: cmd.put_e = 1'b1;
			S_RESULT: cmd.out_load = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SCAN_RD;
				S_SCAN_RD: state_q <= sts.scan_done ? S_DECIDE : S_SCAN_CHK;
				S_SCAN_CHK: state_q <= S_SCAN_RD;
				S_DECIDE: begin
					if (sts.finish_now) state_q <= S_RESULT;
					else if (sts.need_move) state_q <= S_MOVE_RD;
					else state_q <= S_PUT_B;
				end
				S_MOVE_RD: state_q <= S_MOVE_WR;
				S_MOVE_WR: state_q <= sts.move_last ? S_PUT_B : S_MOVE_RD;
				S_PUT_B: state_q <= S_PUT_E;
				S_PUT_E: state_q <= S_RESULT;
				S_RESULT: if (!sts.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> src/irt_datapath.sv
// Datapath with the boundary memories, scan accumulators, shift pointers and result register.
module irt_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  irt_pkg::cmd_t                  cmd,
	output irt_pkg::sts_t                  sts,
	input  logic                           opcode,
	input  logic [irt_pkg::KEY_BITS-1:0]   key_begin,
	input  logic [irt_pkg::KEY_BITS-1:0]   key_end,
	input  logic [irt_pkg::VALUE_BITS-1:0] new_value,
	input  logic                           cfg_valid,
	input  logic [irt_pkg::VALUE_BITS-1:0] base_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [irt_pkg::VALUE_BITS-1:0] read_value,
	output logic [1:0]                     status
);

	localparam int IB = irt_pkg::IDX_BITS;
	localparam int CB = irt_pkg::CNT_BITS;
	localparam int KB = irt_pkg::KEY_BITS;
	localparam int VB = irt_pkg::VALUE_BITS;

	logic          op_q;
	logic [KB-1:0] kb_q, ke_q;
	logic [VB-1:0] nv_q, base_q;
	logic [CB-1:0] count_q, idx_q, lo_q, hi_q, mcnt_q;
	logic [VB-1:0] vb_q, ve_q, vlook_q;
	logic [IB-1:0] src_q, dst_q;
	logic          up_q;
	logic [VB-1:0] rv_q;
	logic [1:0]    stat_q;
	logic          out_valid_q;

	logic [KB-1:0] rd_key;
	logic [VB-1:0] rd_val;
	logic [IB-1:0] raddr, waddr;
	logic          we;
	logic [KB-1:0] wkey;
	logic [VB-1:0] wval;

	logic          put_b, put_e, empty_iv, full;
	logic [CB:0]   ins, dst_base, tail, newcount, up_src, up_dst;

	assign put_b = (nv_q != vb_q);
	assign put_e = (ve_q != nv_q);
	assign ins = (CB+1)'(put_b) + (CB+1)'(put_e);
	assign dst_base = {1'b0, lo_q} + ins;
	assign tail = {1'b0, count_q} - {1'b0, hi_q};
	assign newcount = dst_base + tail;
	assign full = (newcount > (CB+1)'(irt_pkg::TABLE_DEPTH));
	assign empty_iv = !(kb_q < ke_q);
	assign up_src = {1'b0, count_q} - (CB+1)'(1);
	assign up_dst = newcount - (CB+1)'(1);

	assign sts.scan_done = (idx_q == count_q);
	assign sts.finish_now = (op_q == irt_pkg::OP_LOOKUP) || empty_iv || full;
	assign sts.need_move = (tail != '0) && (dst_base != {1'b0, hi_q});
	assign sts.move_last = (mcnt_q == CB'(1));
	assign sts.out_busy = out_valid_q && !out_ready;

	assign raddr = cmd.sel_move ? src_q : idx_q[IB-1:0];

	always_comb begin
		we = 1'b0;
		waddr = dst_q;
		wkey = rd_key;
		wval = rd_val;
		if (cmd.move_wr) begin
			we = 1'b1;
		end else if (cmd.put_b) begin
			we = put_b;
			waddr = lo_q[IB-1:0];
			wkey = kb_q;
			wval = nv_q;
		end else if (cmd.put_e) begin
			we = put_e;
			waddr = dst_base[IB-1:0] - IB'(1);
			wkey = ke_q;
			wval = ve_q;
		end
	end

	irt_ram #(.WIDTH(KB), .DEPTH(irt_pkg::TABLE_DEPTH)) u_key_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wkey),
		.raddr(raddr),
		.rdata(rd_key)
	);

	irt_ram #(.WIDTH(VB), .DEPTH(irt_pkg::TABLE_DEPTH)) u_val_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wval),
		.raddr(raddr),
		.rdata(rd_val)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			kb_q <= key_begin;
			ke_q <= key_end;
			nv_q <= new_value;
			idx_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			vb_q <= base_q;
			ve_q <= base_q;
			vlook_q <= base_q;
		end
		if (cmd.scan_chk) begin
			idx_q <= idx_q + CB'(1);
			if (rd_key < kb_q) begin
				lo_q <= lo_q + CB'(1);
				vb_q <= rd_val;
			end
			if (rd_key <= kb_q) begin
				vlook_q <= rd_val;
			end
			if (rd_key <= ke_q) begin
				hi_q <= hi_q + CB'(1);
				ve_q <= rd_val;
			end
		end
		if (cmd.decide) begin
			if (op_q == irt_pkg::OP_LOOKUP) begin
				rv_q <= vlook_q;
				stat_q <= irt_pkg::ST_DONE;
			end else begin
				rv_q <= '0;
				if (empty_iv) stat_q <= irt_pkg::ST_EMPTY;
				else if (full) stat_q <= irt_pkg::ST_FULL;
				else stat_q <= irt_pkg::ST_DONE;
			end
		end
		if (cmd.move_init) begin
			mcnt_q <= tail[CB-1:0];
			up_q <= (dst_base > {1'b0, hi_q});
			if (dst_base > {1'b0, hi_q}) begin
				src_q <= up_src[IB-1:0];
				dst_q <= up_dst[IB-1:0];
			end else begin
				src_q <= hi_q[IB-1:0];
				dst_q <= dst_base[IB-1:0];
			end
		end
		if (cmd.move_wr) begin
			mcnt_q <= mcnt_q - CB'(1);
			if (up_q) begin
				src_q <= src_q - IB'(1);
				dst_q <= dst_q - IB'(1);
			end else begin
				src_q <= src_q + IB'(1);
				dst_q <= dst_q + IB'(1);
			end
		end
		if (cmd.out_load) begin
			read_value <= rv_q;
			status <= stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			base_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				base_q <= base_value;
			end
			if (cmd.put_e) begin
				count_q <= newcount[CB-1:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> src/interval_range_table_unit.sv
// Top level of the interval range table: controller, datapath and ports.
//
//  channel  | handshake           | payload
//  in       | in_valid, in_ready  | opcode, key_begin, key_end, new_value
//  out      | out_valid, out_ready| read_value, status
//  cfg      | cfg_valid, cfg_ready| base_value
//
// One item is worked on at a time; a lookup scans every entry and an assign
// also shifts the entries behind the interval where they must move, all through
// the single read port of the boundary memories.
// Reset empties the table and clears the stored base value at once; no clearing pass runs.
// A result waiting on out_ready holds the block in its last step, not the next item.
module interval_range_table_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           opcode,
	input  logic [irt_pkg::KEY_BITS-1:0]   key_begin,
	input  logic [irt_pkg::KEY_BITS-1:0]   key_end,
	input  logic [irt_pkg::VALUE_BITS-1:0] new_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [irt_pkg::VALUE_BITS-1:0] read_value,
	output logic [1:0]                     status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [irt_pkg::VALUE_BITS-1:0] base_value
);

	irt_pkg::cmd_t cmd;
	irt_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	irt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	irt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.opcode    (opcode),
		.key_begin (key_begin),
		.key_end   (key_end),
		.new_value (new_value),
		.cfg_valid (cfg_valid),
		.base_value(base_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_value(read_value),
		.status    (status)
	);

endmodule

>>> src/irt_checker.sv
// Port-level checker for the interval range table and its bind to the top level.
module irt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [irt_pkg::VALUE_BITS-1:0] read_value,
	input logic [1:0]                     status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(status))
		else $error("result item changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != irt_pkg::ST_DONE |-> read_value == '0)
		else $error("rejected assign carries a nonzero value");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");

endmodule

bind interval_range_table_unit irt_checker u_irt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.read_value(read_value),
	.status    (status)
);

>>> bench/tb_top.sv
// Testbench for the interval range table unit: a self-checking run of lookups and assigns.
`timescale 1ns / 1ps
module tb_top;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = irt_pkg::OP_LOOKUP;
	logic [irt_pkg::KEY_BITS-1:0] key_begin = '0;
	logic [irt_pkg::KEY_BITS-1:0] key_end = '0;
	logic [irt_pkg::VALUE_BITS-1:0] new_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [irt_pkg::VALUE_BITS-1:0] read_value;
	logic [1:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [irt_pkg::VALUE_BITS-1:0] base_value = '0;

	interval_range_table_unit u_top (.*);

	always #1 clk = ~clk;

	typedef struct {
		logic [irt_pkg::VALUE_BITS-1:0] value;
		logic [1:0] code;
	} answer_t;

	logic [irt_pkg::KEY_BITS-1:0] bound_key[irt_pkg::TABLE_DEPTH];
	logic [irt_pkg::VALUE_BITS-1:0] bound_val[irt_pkg::TABLE_DEPTH];
	int bound_count = 0;
	logic [irt_pkg::VALUE_BITS-1:0] base_copy = '0;
	answer_t answers[$];
	int mismatches = 0;
	int sent = 0;
	int lookups = 0;
	int rejects = 0;
	int cycles = 0;
	bit hold_off = 1'b0;
	bit bursty = 1'b1;

	function automatic int keys_below(logic [irt_pkg::KEY_BITS-1:0] k, bit strict);
		int i;
		i = 0;
		while (i < bound_count && (strict ? bound_key[i] < k : bound_key[i] <= k))
			i++;
		return i;
	endfunction

	function automatic logic [irt_pkg::VALUE_BITS-1:0] value_of(
			logic [irt_pkg::KEY_BITS-1:0] k);
		int n;
		n = keys_below(k, 1'b0);
		return n ? bound_val[n-1] : base_copy;
	endfunction

	function automatic logic [1:0] apply_range(logic [irt_pkg::KEY_BITS-1:0] b,
			logic [irt_pkg::KEY_BITS-1:0] e, logic [irt_pkg::VALUE_BITS-1:0] v);
		int lo, hi, ins, tail, total;
		logic [irt_pkg::VALUE_BITS-1:0] vb, ve;
		bit pb, pe;
		logic [irt_pkg::KEY_BITS-1:0] tk[irt_pkg::TABLE_DEPTH];
		logic [irt_pkg::VALUE_BITS-1:0] tv[irt_pkg::TABLE_DEPTH];
		if (!(b < e))
			return irt_pkg::ST_EMPTY;
		lo = keys_below(b, 1'b1);
		hi = keys_below(e, 1'b0);
		vb = lo ? bound_val[lo-1] : base_copy;
		ve = hi ? bound_val[hi-1] : base_copy;
		pb = v != vb;
		pe = ve != v;
		ins = int'(pb) + int'(pe);
		tail = bound_count - hi;
		total = lo + ins + tail;
		if (total > irt_pkg::TABLE_DEPTH)
			return irt_pkg::ST_FULL;
		for (int i = 0; i < tail; i++) begin
			tk[i] = bound_key[hi+i];
			tv[i] = bound_val[hi+i];
		end
		for (int i = 0; i < tail; i++) begin
			bound_key[lo+ins+i] = tk[i];
			bound_val[lo+ins+i] = tv[i];
		end
		if (pb) begin
			bound_key[lo] = b;
			bound_val[lo] = v;
			lo++;
		end
		if (pe) begin
			bound_key[lo] = e;
			bound_val[lo] = ve;
		end
		bound_count = total;
		return irt_pkg::ST_DONE;
	endfunction

	function automatic int pick_gap();
		if (!bursty)
			return 0;
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
	endfunction

	task automatic send_item(logic op, logic [irt_pkg::KEY_BITS-1:0] b,
			logic [irt_pkg::KEY_BITS-1:0] e, logic [irt_pkg::VALUE_BITS-1:0] v);
		answer_t a;
		int gap;
		gap = pick_gap();
		repeat (gap + 1) @(posedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		key_begin <= b;
		key_end <= e;
		new_value <= v;
		do @(posedge clk); while (!in_ready);
		in_valid <= 1'b0;
		if (op == irt_pkg::OP_LOOKUP) begin
			a.value = value_of(b);
			a.code = irt_pkg::ST_DONE;
			lookups++;
		end else begin
			a.value = '0;
			a.code = apply_range(b, e, v);
			if (a.code == irt_pkg::ST_FULL)
				rejects++;
		end
		answers.push_back(a);
		sent++;
	endtask

	task automatic write_base(logic [irt_pkg::VALUE_BITS-1:0] v);
		wait (answers.size() == 0);
		repeat (300) @(posedge clk);
		cfg_valid <= 1'b1;
		base_value <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_copy = v;
	endtask

	always @(posedge clk) begin
		answer_t a;
		if (out_valid && out_ready) begin
			if (answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result value=%h status=%0d", read_value, status);
			end else begin
				a = answers.pop_front();
				if (read_value !== a.value || status !== a.code) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
							a.value, a.code, read_value, status);
				end
			end
		end
	end

	initial begin
		int wait_left;
		wait_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off)
				out_ready <= 1'b0;
			else if (wait_left > 0) begin
				wait_left--;
				out_ready <= 1'b0;
			end else begin
				wait_left = pick_gap();
				out_ready <= (wait_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 4000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [irt_pkg::KEY_BITS-1:0] near_key();
		return $urandom_range(0, 3) == 0 ? irt_pkg::KEY_BITS'($urandom)
			: irt_pkg::KEY_BITS'($urandom_range(0, 255));
	endfunction

	task automatic test_directed();
		send_item(irt_pkg::OP_LOOKUP, 16'h0000, 16'h0, 32'h0);
		send_item(irt_pkg::OP_ASSIGN, 16'd10, 16'd10, 32'h1234);
		send_item(irt_pkg::OP_ASSIGN, 16'd20, 16'd10, 32'h1234);
		send_item(irt_pkg::OP_ASSIGN, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(irt_pkg::OP_LOOKUP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(irt_pkg::OP_LOOKUP, 16'hFFFE, 16'h0, 32'h0);
		send_item(irt_pkg::OP_ASSIGN, 16'd5, 16'd9, 32'h0);
		send_item(irt_pkg::OP_ASSIGN, 16'd7, 16'd8, 32'hFFFF_FFFF);
		send_item(irt_pkg::OP_LOOKUP, 16'd7, 16'h0, 32'h0);
		send_item(irt_pkg::OP_LOOKUP, 16'd8, 16'h0, 32'h0);
		send_item(irt_pkg::OP_ASSIGN, 16'd0, 16'hFFFF, 32'h0);
		send_item(irt_pkg::OP_LOOKUP, 16'd100, 16'h0, 32'h0);
		for (int i = 0; i < 70; i += 2)
			send_item(irt_pkg::OP_ASSIGN, 16'(i * 3), 16'(i * 3 + 1), 32'(i + 1));
		send_item(irt_pkg::OP_LOOKUP, 16'd3, 16'h0, 32'h0);
	endtask

	task automatic test_base_rewrite();
		write_base(32'hFFFF_FFFF);
		send_item(irt_pkg::OP_LOOKUP, 16'd2, 16'h0, 32'h0);
		send_item(irt_pkg::OP_ASSIGN, 16'd0, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(irt_pkg::OP_LOOKUP, 16'hFFFF, 16'h0, 32'h0);
		write_base(32'h0);
		send_item(irt_pkg::OP_LOOKUP, 16'd0, 16'h0, 32'h0);
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (2000) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 12; i++)
				send_item(1'($urandom_range(0, 1)), near_key(), near_key(), $urandom);
		join
	endtask

	task automatic test_random(int count);
		logic [irt_pkg::KEY_BITS-1:0] b;
		for (int i = 0; i < count; i++) begin
			if (i % 500 == 250) begin
				write_base($urandom_range(0, 1) ? $urandom : 32'h0);
				bursty = ~bursty;
			end
			b = near_key();
			if ($urandom_range(0, 9) < 4)
				send_item(irt_pkg::OP_LOOKUP, b, irt_pkg::KEY_BITS'($urandom), $urandom);
			else if ($urandom_range(0, 19) == 0)
				send_item(irt_pkg::OP_ASSIGN, b, irt_pkg::KEY_BITS'($urandom), $urandom);
			else
				send_item(irt_pkg::OP_ASSIGN, b,
					b + irt_pkg::KEY_BITS'($urandom_range(1, 40)),
					$urandom_range(0, 1) ? 32'($urandom_range(0, 5)) : $urandom);
		end
		bursty = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_base(32'h0);
		test_directed();
		test_base_rewrite();
		test_backpressure();
		test_random(2000);
		wait (answers.size() == 0);
		repeat (400) @(posedge clk);
		$display("Sent %0d items: %0d lookups, %0d assigns rejected as full.",
			sent, lookups, rejects);
		$display("Covered empty intervals, full table, base rewrites and output stalls.");
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
